### src/olm_pkg.sv
// Shared types and constants for the optical latency meter.
package olm_pkg;

  // Default widths of the sample and of the tick counters.
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 24;

  // Fixed widths of the configuration registers and statistics.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned TICKS_W    = 24;
  localparam int unsigned TRIALS_W   = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SUM_W      = 32;

  // Register values after reset.
  localparam logic [TICKS_W-1:0]  TIMEOUT_RST  = 24'd500000;
  localparam logic [TICKS_W-1:0]  SETTLE_RST   = 24'd500000;
  localparam logic [TRIALS_W-1:0] TRIAL_CNT_RST = 8'd150;
  localparam logic [PCT_W-1:0]    HI_PCT_RST   = 7'd80;
  localparam logic [PCT_W-1:0]    LO_PCT_RST   = 7'd20;

  // Exact unsigned divide by 100 for any 32-bit dividend: (x * MAGIC) >> SHIFT.
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int unsigned DIV100_SHIFT = 37;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 3'd0,
    CFG_SETTLE    = 3'd1,
    CFG_TRIAL_CNT = 3'd2,
    CFG_HI_PCT    = 3'd3,
    CFG_LO_PCT    = 3'd4
  } cfg_idx_e;

  // Measurement phases.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_CAL_ON   = 3'd1,
    PH_CAL_OFF  = 3'd2,
    PH_WAIT_ON  = 3'd3,
    PH_WAIT_OFF = 3'd4
  } phase_e;

  // Single-bit status of one result item.
  typedef struct packed {
    logic led;
    logic busy;
    logic trial_done;
    logic trial_valid;
    logic run_done;
  } flags_t;

endpackage

### src/olm_in_reg.sv
// Input register stage holding one accepted tick item.
module olm_in_reg import olm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] light_sample_i,
  input  logic                   start_req_i,
  input  logic                   adv_i,
  output logic                   proc_o,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   start_o
);

  logic                   vld_q, vld_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   start_q;
  logic                   load;

  // The stage is free when empty or when its item moves on this cycle.
  assign in_stall_o = vld_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;
  assign vld_d      = (!vld_q || adv_i) ? in_valid_i : 1'b1;
  assign proc_o     = vld_q && adv_i;
  assign sample_o   = sample_q;
  assign start_o    = start_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= light_sample_i;
      start_q  <= start_req_i;
    end
  end

endmodule

### src/olm_thresh.sv
// Two-stage threshold unit: percent products, then divide by 100.
module olm_thresh import olm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS:0]   delta_i,
  input  logic [PCT_W-1:0]              hi_pct_i,
  input  logic [PCT_W-1:0]              lo_pct_i,
  output logic signed [SAMPLE_BITS+1:0] hi_thr_o,
  output logic signed [SAMPLE_BITS+1:0] lo_thr_o
);

  localparam int unsigned MAG_W  = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = MAG_W + PCT_W;
  localparam int unsigned THR_W  = SAMPLE_BITS + 2;

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] hi_prod_q, lo_prod_q;
  logic              neg_q;
  logic              pend_q;
  logic [63:0]       hi_quo, lo_quo;
  logic [MAG_W-1:0]  hi_div, lo_div;
  logic signed [THR_W-1:0] hi_thr_d, lo_thr_d, hi_thr_q, lo_thr_q;

  // Magnitude of the on level; the sign is put back after the divide.
  assign mag = delta_i[SAMPLE_BITS] ? MAG_W'(-delta_i) : MAG_W'(delta_i);

  // First stage: magnitude times percent.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hi_prod_q <= PROD_W'(mag * hi_pct_i);
      lo_prod_q <= PROD_W'(mag * lo_pct_i);
      neg_q     <= delta_i[SAMPLE_BITS];
    end
  end

  // Second stage: divide by 100 via reciprocal, truncating toward zero.
  assign hi_quo = (64'(hi_prod_q) * 64'(DIV100_MAGIC)) >> DIV100_SHIFT;
  assign lo_quo = (64'(lo_prod_q) * 64'(DIV100_MAGIC)) >> DIV100_SHIFT;
  assign hi_div = hi_quo[MAG_W-1:0];
  assign lo_div = lo_quo[MAG_W-1:0];
  assign hi_thr_d = neg_q ? -signed'({1'b0, hi_div}) : signed'({1'b0, hi_div});
  assign lo_thr_d = neg_q ? -signed'({1'b0, lo_div}) : signed'({1'b0, lo_div});

  // Pending flag and threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      hi_thr_q <= '0;
      lo_thr_q <= '0;
    end else begin
      pend_q <= load_i;
      if (pend_q) begin
        hi_thr_q <= hi_thr_d;
        lo_thr_q <= lo_thr_d;
      end
    end
  end

  assign hi_thr_o = hi_thr_q;
  assign lo_thr_o = lo_thr_q;

endmodule

### src/olm_core.sv
// Measurement sequencer: configuration, phase control and run statistics.
module olm_core import olm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          proc_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS+1:0] hi_thr_i,
  input  logic signed [SAMPLE_BITS+1:0] lo_thr_i,
  output logic                          cal_load_o,
  output logic signed [SAMPLE_BITS:0]   cal_delta_o,
  output logic [PCT_W-1:0]              hi_pct_o,
  output logic [PCT_W-1:0]              lo_pct_o,
  output flags_t                        flags_o,
  output logic [COUNT_BITS-1:0]         trial_latency_o,
  output logic [TRIALS_W-1:0]           accepted_count_o,
  output logic [SUM_W-1:0]              latency_sum_o,
  output logic [COUNT_BITS-1:0]         latency_min_o,
  output logic [COUNT_BITS-1:0]         latency_max_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

  // Configuration registers.
  logic [TICKS_W-1:0]  timeout_q, settle_q;
  logic [TRIALS_W-1:0] trial_cnt_q;
  logic [PCT_W-1:0]    hi_pct_q, lo_pct_q;

  // Sequencer state.
  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [SAMPLE_BITS-1:0] bias_q, bias_d;
  logic [COUNT_BITS-1:0] on_time_q, on_time_d;
  logic                  on_valid_q, on_valid_d;
  logic [TRIALS_W-1:0]   trials_q, trials_d;
  logic [TRIALS_W-1:0]   vcount_q, vcount_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [COUNT_BITS-1:0] min_q, min_d;
  logic [COUNT_BITS-1:0] max_q, max_d;

  logic signed [SAMPLE_BITS:0]   delta;
  logic signed [SAMPLE_BITS+1:0] delta_x;
  logic                  settled, expired, off_ok, cal_load;
  logic [COUNT_BITS-1:0] tick_inc;
  logic [COUNT_BITS:0]   lat_sum;
  logic [COUNT_BITS-1:0] lat, t_lat;
  logic [TRIALS_W-1:0]   trials_inc;
  logic                  t_done, t_valid, r_done;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RST;
      settle_q    <= SETTLE_RST;
      trial_cnt_q <= TRIAL_CNT_RST;
      hi_pct_q    <= HI_PCT_RST;
      lo_pct_q    <= LO_PCT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[TICKS_W-1:0];
        CFG_SETTLE:    settle_q    <= cfg_wdata_i[TICKS_W-1:0];
        CFG_TRIAL_CNT: trial_cnt_q <= cfg_wdata_i[TRIALS_W-1:0];
        CFG_HI_PCT:    hi_pct_q    <= cfg_wdata_i[PCT_W-1:0];
        CFG_LO_PCT:    lo_pct_q    <= cfg_wdata_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared terms of the phase logic.
  assign delta      = signed'({1'b0, sample_i}) - signed'({1'b0, bias_q});
  assign delta_x    = {delta[SAMPLE_BITS], delta};
  assign settled    = CMP_W'(tick_q) >= CMP_W'(settle_q);
  assign expired    = (CMP_W'(tick_q) > CMP_W'(timeout_q)) || (tick_q == '1);
  assign tick_inc   = (tick_q == '1) ? tick_q : tick_q + 1'b1;
  assign lat_sum    = {1'b0, on_time_q} + {1'b0, tick_q};
  assign lat        = lat_sum[COUNT_BITS:1];
  assign trials_inc = trials_q + 1'b1;

  // Next state and result of one tick.
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bias_d     = bias_q;
    on_time_d  = on_time_q;
    on_valid_d = on_valid_q;
    trials_d   = trials_q;
    vcount_d   = vcount_q;
    sum_d      = sum_q;
    min_d      = min_q;
    max_d      = max_q;
    off_ok     = 1'b0;
    cal_load   = 1'b0;
    t_done     = 1'b0;
    t_valid    = 1'b0;
    t_lat      = '0;
    r_done     = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          bias_d   = sample_i;
          tick_d   = '0;
          trials_d = '0;
          vcount_d = '0;
          sum_d    = '0;
          min_d    = '1;
          max_d    = '0;
          phase_d  = PH_CAL_ON;
        end
      end
      PH_CAL_ON: begin
        if (settled) begin
          cal_load = 1'b1;
          tick_d   = '0;
          phase_d  = PH_CAL_OFF;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_CAL_OFF: begin
        if (settled) begin
          tick_d  = '0;
          phase_d = PH_WAIT_ON;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_WAIT_ON: begin
        if (expired) begin
          on_valid_d = 1'b0;
          on_time_d  = '0;
          tick_d     = '0;
          phase_d    = PH_WAIT_OFF;
        end else if (delta_x > hi_thr_i) begin
          on_valid_d = 1'b1;
          on_time_d  = tick_q;
          tick_d     = '0;
          phase_d    = PH_WAIT_OFF;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_WAIT_OFF: begin
        if (expired || (delta_x < lo_thr_i)) begin
          off_ok = !expired;
          t_done = 1'b1;
          if (on_valid_q && off_ok) begin
            t_lat = lat;
            if (lat != '0) begin
              t_valid  = 1'b1;
              vcount_d = vcount_q + 1'b1;
              sum_d    = sum_q + SUM_W'(lat);
              if (lat < min_q) min_d = lat;
              if (lat > max_q) max_d = lat;
            end
          end
          trials_d = trials_inc;
          tick_d   = '0;
          if (trials_inc >= trial_cnt_q) begin
            r_done  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_WAIT_ON;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bias_q     <= '0;
      on_time_q  <= '0;
      on_valid_q <= 1'b0;
      trials_q   <= '0;
      vcount_q   <= '0;
      sum_q      <= '0;
      min_q      <= '1;
      max_q      <= '0;
    end else if (proc_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bias_q     <= bias_d;
      on_time_q  <= on_time_d;
      on_valid_q <= on_valid_d;
      trials_q   <= trials_d;
      vcount_q   <= vcount_d;
      sum_q      <= sum_d;
      min_q      <= min_d;
      max_q      <= max_d;
    end
  end

  // Calibration request to the threshold unit.
  assign cal_load_o  = proc_i && cal_load;
  assign cal_delta_o = delta;
  assign hi_pct_o    = hi_pct_q;
  assign lo_pct_o    = lo_pct_q;

  // Result of this tick, taken from the updated state.
  assign flags_o.led         = (phase_d == PH_CAL_ON) || (phase_d == PH_WAIT_ON);
  assign flags_o.busy        = (phase_d != PH_IDLE);
  assign flags_o.trial_done  = t_done;
  assign flags_o.trial_valid = t_valid;
  assign flags_o.run_done    = r_done;
  assign trial_latency_o     = t_lat;
  assign accepted_count_o    = vcount_d;
  assign latency_sum_o       = sum_d;
  assign latency_min_o       = min_d;
  assign latency_max_o       = max_d;

endmodule

### src/olm_out_reg.sv
// Result register stage holding one item for the receiver.
module olm_out_reg import olm_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  proc_i,
  output logic                  adv_o,
  input  flags_t                flags_i,
  input  logic [COUNT_BITS-1:0] trial_latency_i,
  input  logic [TRIALS_W-1:0]   accepted_count_i,
  input  logic [SUM_W-1:0]      latency_sum_i,
  input  logic [COUNT_BITS-1:0] latency_min_i,
  input  logic [COUNT_BITS-1:0] latency_max_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  led_drive_o,
  output logic                  busy_res_o,
  output logic                  trial_done_o,
  output logic                  trial_valid_o,
  output logic [COUNT_BITS-1:0] trial_latency_o,
  output logic                  run_done_o,
  output logic [TRIALS_W-1:0]   accepted_count_o,
  output logic [SUM_W-1:0]      latency_sum_o,
  output logic [COUNT_BITS-1:0] latency_min_o,
  output logic [COUNT_BITS-1:0] latency_max_o
);

  logic                  vld_q, vld_d;
  flags_t                flags_q;
  logic [COUNT_BITS-1:0] lat_q, min_q, max_q;
  logic [TRIALS_W-1:0]   cnt_q;
  logic [SUM_W-1:0]      sum_q;

  // The register can take a new item when empty or when its item leaves.
  assign adv_o = !vld_q || !out_stall_i;
  assign vld_d = proc_i || (vld_q && out_stall_i);

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (proc_i) begin
      flags_q <= flags_i;
      lat_q   <= trial_latency_i;
      cnt_q   <= accepted_count_i;
      sum_q   <= latency_sum_i;
      min_q   <= latency_min_i;
      max_q   <= latency_max_i;
    end
  end

  assign out_valid_o      = vld_q;
  assign led_drive_o      = flags_q.led;
  assign busy_res_o       = flags_q.busy;
  assign trial_done_o     = flags_q.trial_done;
  assign trial_valid_o    = flags_q.trial_valid;
  assign run_done_o       = flags_q.run_done;
  assign trial_latency_o  = lat_q;
  assign accepted_count_o = cnt_q;
  assign latency_sum_o    = sum_q;
  assign latency_min_o    = min_q;
  assign latency_max_o    = max_q;

endmodule

### src/optical_latency_meter.sv
// Top level of the optical latency meter.
//
// Each input item is one microsecond tick carrying a light sample and a start
// request; each item yields exactly one result item with the LED drive, run
// status, trial outcome and the current run statistics.
// Both channels use valid/stall: an item moves at a clock edge where valid is
// high and stall is low. The block takes one item per cycle while the
// receiver does not stall. An accepted item waits in the input register; its
// result is then held in the result register until taken. The threshold divide
// runs in two stages beside the main path; a calibration result is ready
// before the first tick that uses it.
// When the receiver stalls, the result register holds; the next item then
// waits in the input register and the input stall rises only once both are
// full. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i and
// takes effect for the next processed item.
// Reset empties both registers, puts the sequencer in idle, clears the run
// statistics (minimum to all ones) and loads the default configuration.
module optical_latency_meter import olm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] light_sample_i,
  input  logic                   start_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   led_drive_o,
  output logic                   busy_res_o,
  output logic                   trial_done_o,
  output logic                   trial_valid_o,
  output logic [COUNT_BITS-1:0]  trial_latency_o,
  output logic                   run_done_o,
  output logic [TRIALS_W-1:0]    accepted_count_o,
  output logic [SUM_W-1:0]       latency_sum_o,
  output logic [COUNT_BITS-1:0]  latency_min_o,
  output logic [COUNT_BITS-1:0]  latency_max_o
);

  logic                          adv, proc;
  logic [SAMPLE_BITS-1:0]        sample;
  logic                          start;
  logic                          cal_load;
  logic signed [SAMPLE_BITS:0]   cal_delta;
  logic [PCT_W-1:0]              hi_pct, lo_pct;
  logic signed [SAMPLE_BITS+1:0] hi_thr, lo_thr;
  flags_t                        flags;
  logic [COUNT_BITS-1:0]         t_lat, lat_min, lat_max;
  logic [TRIALS_W-1:0]           acc_cnt;
  logic [SUM_W-1:0]              lat_sum;

  // Input register.
  olm_in_reg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .light_sample_i(light_sample_i),
    .start_req_i   (start_req_i),
    .adv_i         (adv),
    .proc_o        (proc),
    .sample_o      (sample),
    .start_o       (start)
  );

  // Threshold computation after calibration.
  olm_thresh #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_thresh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cal_load),
    .delta_i (cal_delta),
    .hi_pct_i(hi_pct),
    .lo_pct_i(lo_pct),
    .hi_thr_o(hi_thr),
    .lo_thr_o(lo_thr)
  );

  // Sequencer and statistics.
  olm_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .proc_i          (proc),
    .sample_i        (sample),
    .start_i         (start),
    .hi_thr_i        (hi_thr),
    .lo_thr_i        (lo_thr),
    .cal_load_o      (cal_load),
    .cal_delta_o     (cal_delta),
    .hi_pct_o        (hi_pct),
    .lo_pct_o        (lo_pct),
    .flags_o         (flags),
    .trial_latency_o (t_lat),
    .accepted_count_o(acc_cnt),
    .latency_sum_o   (lat_sum),
    .latency_min_o   (lat_min),
    .latency_max_o   (lat_max)
  );

  // Result register.
  olm_out_reg #(
    .COUNT_BITS(COUNT_BITS)
  ) u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .proc_i          (proc),
    .adv_o           (adv),
    .flags_i         (flags),
    .trial_latency_i (t_lat),
    .accepted_count_i(acc_cnt),
    .latency_sum_i   (lat_sum),
    .latency_min_i   (lat_min),
    .latency_max_i   (lat_max),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .led_drive_o     (led_drive_o),
    .busy_res_o      (busy_res_o),
    .trial_done_o    (trial_done_o),
    .trial_valid_o   (trial_valid_o),
    .trial_latency_o (trial_latency_o),
    .run_done_o      (run_done_o),
    .accepted_count_o(accepted_count_o),
    .latency_sum_o   (latency_sum_o),
    .latency_min_o   (latency_min_o),
    .latency_max_o   (latency_max_o)
  );

endmodule
